### rtl/lzw_compressor_12bit_unit_defines.svh
// assertion macros shared by the rtl files
`ifndef LZW_COMPRESSOR_12BIT_UNIT_DEFINES_SVH
`define LZW_COMPRESSOR_12BIT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LZWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LZWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lzwc_pkg.sv
package lzwc_pkg;

  localparam int unsigned FIRST_FREE = 256;
  localparam int unsigned ACC_BITS   = 32;
  localparam int unsigned CNT_BITS   = 5;
  localparam int unsigned EPOCH_BITS = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  typedef struct packed {
    logic valid;
    logic flush;
  } code_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_PUSH_MISS,
    ST_PUSH_CUR,
    ST_PUSH_END,
    ST_PUSH_FLUSH
  } state_e;

endpackage

### rtl/lzwc_ram.sv
module lzwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lzwc_packer.sv
`include "lzw_compressor_12bit_unit_defines.svh"

module lzwc_packer import lzwc_pkg::*; #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  code_req_t            code_req_i,
  input  logic [CODE_BITS-1:0] code_i,
  output logic                 code_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_req_t             out_req_o
);

  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  pend_last_q, pend_last_d;
  logic                  out_valid_q, out_valid_d;
  out_req_t              out_q, out_d;
  logic                  code_take;
  logic                  byte_go;
  logic [CNT_BITS:0]     shamt;

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    code_ready_o = (cnt_q < CNT_BITS'(8));
    code_take    = code_req_i.valid && code_ready_o;
    byte_go      = (cnt_q >= CNT_BITS'(8)) && (!out_valid_q || out_ready_i);
    shamt        = (CNT_BITS + 1)'(ACC_BITS - CODE_BITS) - {1'b0, cnt_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    // new code lands just below the bits still waiting
    if (code_take) begin
      acc_d = acc_q | (ACC_BITS'(code_i) << shamt);
      cnt_d = cnt_q + CNT_BITS'(CODE_BITS);
      if (code_req_i.flush) begin
        pend_last_d = 1'b1;
      end
    end
    if (byte_go) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = acc_q[ACC_BITS-1 -: 8];
      out_d.out_last    = pend_last_q && (cnt_q < CNT_BITS'(16));
      if (out_d.out_last) begin
        pend_last_d = 1'b0;
      end
      acc_d = acc_q << 8;
      cnt_d = cnt_q - CNT_BITS'(8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `LZWC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q < CNT_BITS'(8 + CODE_BITS), "bit count overflow")
  `LZWC_ASSERT_IMP(a_flush_once, code_take && code_req_i.flush, !pend_last_q, "flush overlap")
  `LZWC_ASSERT_NEXT(a_last_drains, byte_go && out_d.out_last, cnt_q < CNT_BITS'(8),
                    "last byte left full bytes behind")

endmodule

### rtl/lzw_compressor_12bit_unit.sv
// LZW compressor, fixed-width codes packed MSB first into bytes.
// Input channel: in_valid_i/in_ready_o with in_req_i (data_byte, last_byte).
// Output channel: out_valid_o/out_ready_i with out_req_o (out_byte, out_last).
// The first byte of a message starts a fresh dictionary. On the last byte the
// current code, the end code and a zero flush code are sent, and out_last marks
// the final byte of that message. Leftover bits lead the next message.
// Steps per byte: the first byte of a message needs no dictionary lookup. Any
// other byte passes ST_HASH and then ST_CHECK once per dictionary probe
// (normally one), the read-check loop on the single dictionary memory. A
// byte that emits codes passes one push state per code, each waiting until the
// packer has room; a code that follows another waits for the packer to drain.
// The dictionary is cleared by message tags; after reset, and when the tag
// counter wraps (every 255th message start), a clearing pass writes all
// HASH_TABLE_SIZE entries at one per cycle, with in_ready_o low meanwhile.
// The output byte sits in a register: a stalled receiver holds it there, the
// packer then stops taking codes and input acceptance stops once a code waits.
// Reset is asynchronous, active low, and starts the clearing pass.
`include "lzw_compressor_12bit_unit_defines.svh"

module lzw_compressor_12bit_unit import lzwc_pkg::*; #(
  parameter int unsigned CODE_BITS       = 12,
  parameter int unsigned HASH_TABLE_SIZE = 5021
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  localparam int unsigned SLOT_W    = $clog2(HASH_TABLE_SIZE);
  localparam int unsigned PW        = SLOT_W + 1;
  localparam int unsigned PROBE_W   = $clog2(HASH_TABLE_SIZE + 1);
  localparam int unsigned HASH_SPAN = 2 ** CODE_BITS;
  localparam int unsigned NSTEP_RAW =
    $clog2((HASH_SPAN + HASH_TABLE_SIZE - 1) / HASH_TABLE_SIZE);
  localparam int unsigned NSTEP     = (NSTEP_RAW < 1) ? 1 : NSTEP_RAW;
  localparam int unsigned STEP_W    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int unsigned REM_W     = CODE_BITS + SLOT_W;
  localparam logic [CODE_BITS-1:0] END_CODE = '1;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [CODE_BITS-1:0]  code;
    logic [CODE_BITS-1:0]  prefix;
    logic [7:0]            chr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  state_e                state_q, state_d;
  logic [EPOCH_BITS-1:0] epoch_q, epoch_d;
  logic                  first_q, first_d;
  logic                  last_q, last_d;
  logic [7:0]            ch_q, ch_d;
  logic [CODE_BITS-1:0]  cur_q, cur_d;
  logic [CODE_BITS-1:0]  free_q, free_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [PW-1:0]         dstep_q, dstep_d;
  logic [PROBE_W-1:0]    probes_q, probes_d;
  logic [SLOT_W-1:0]     clr_q, clr_d;

  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
  entry_t                ram_wdata, rd_entry;
  logic [ENTRY_W-1:0]    ram_rdata;

  code_req_t             code_req;
  logic [CODE_BITS-1:0]  code;
  logic                  code_ready;

  logic                  in_take;
  logic [CODE_BITS-1:0]  hash_in;
  logic [REM_W-1:0]      rem_mult, rem_nx;
  logic                  ent_valid, hit, exhausted;
  logic [PW-1:0]         size_w, slot_ext, pstep, nslot_w;
  logic [SLOT_W-1:0]     slot_nx;

  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    state_d    = state_q;
    epoch_d    = epoch_q;
    first_d    = first_q;
    last_d     = last_q;
    ch_d       = ch_q;
    cur_d      = cur_q;
    free_d     = free_q;
    rem_d      = rem_q;
    step_d     = step_q;
    slot_d     = slot_q;
    dstep_d    = dstep_q;
    probes_d   = probes_q;
    clr_d      = clr_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = slot_q;
    ram_raddr  = slot_q;
    ram_wdata  = '0;
    code_req   = '0;
    code       = cur_q;
    in_ready_o = (state_q == ST_IDLE);
    in_take    = in_valid_i && in_ready_o;

    hash_in  = CODE_BITS'({in_req_i.data_byte, {(CODE_BITS - 8){1'b0}}}) ^ cur_q;
    rem_mult = REM_W'(HASH_TABLE_SIZE) << step_q;
    rem_nx   = (rem_q >= rem_mult) ? (rem_q - rem_mult) : rem_q;

    ent_valid = (rd_entry.tag == epoch_q);
    hit       = ent_valid && (rd_entry.prefix == cur_q) && (rd_entry.chr == ch_q);
    exhausted = (probes_q == PROBE_W'(HASH_TABLE_SIZE));
    size_w    = PW'(HASH_TABLE_SIZE);
    slot_ext  = {1'b0, slot_q};
    // probe stride is fixed by the home slot
    pstep     = (rem_nx[SLOT_W-1:0] == '0) ? PW'(1) :
                (size_w - {1'b0, rem_nx[SLOT_W-1:0]});
    nslot_w   = (slot_ext >= dstep_q) ? (slot_ext - dstep_q) :
                (slot_ext + size_w - dstep_q);
    slot_nx   = nslot_w[SLOT_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(HASH_TABLE_SIZE - 1)) begin
          state_d = last_q ? ST_PUSH_CUR : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          ch_d   = in_req_i.data_byte;
          last_d = in_req_i.last_byte;
          if (first_q) begin
            cur_d   = CODE_BITS'(in_req_i.data_byte);
            free_d  = CODE_BITS'(FIRST_FREE);
            first_d = 1'b0;
            if (epoch_q == '1) begin
              epoch_d = EPOCH_BITS'(1);
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_BITS'(1);
              state_d = in_req_i.last_byte ? ST_PUSH_CUR : ST_IDLE;
            end
          end else begin
            rem_d   = REM_W'(hash_in);
            step_d  = STEP_W'(NSTEP - 1);
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        // home slot by restoring reduction, one multiple per cycle
        rem_d = rem_nx;
        if (step_q == '0) begin
          slot_d    = rem_nx[SLOT_W-1:0];
          dstep_d   = pstep;
          ram_re    = 1'b1;
          ram_raddr = rem_nx[SLOT_W-1:0];
          probes_d  = PROBE_W'(1);
          state_d   = ST_CHECK;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_CHECK: begin
        if (hit) begin
          cur_d   = rd_entry.code;
          state_d = last_q ? ST_PUSH_CUR : ST_IDLE;
        end else if (!ent_valid) begin
          if (free_q != END_CODE) begin
            ram_we           = 1'b1;
            ram_waddr        = slot_q;
            ram_wdata.tag    = epoch_q;
            ram_wdata.code   = free_q;
            ram_wdata.prefix = cur_q;
            ram_wdata.chr    = ch_q;
            free_d           = free_q + CODE_BITS'(1);
          end
          state_d = ST_PUSH_MISS;
        end else if (exhausted) begin
          state_d = ST_PUSH_MISS;
        end else begin
          slot_d    = slot_nx;
          ram_re    = 1'b1;
          ram_raddr = slot_nx;
          probes_d  = probes_q + PROBE_W'(1);
        end
      end
      ST_PUSH_MISS: begin
        code_req.valid = 1'b1;
        code           = cur_q;
        if (code_ready) begin
          cur_d   = CODE_BITS'(ch_q);
          state_d = last_q ? ST_PUSH_CUR : ST_IDLE;
        end
      end
      ST_PUSH_CUR: begin
        code_req.valid = 1'b1;
        code           = cur_q;
        if (code_ready) begin
          state_d = ST_PUSH_END;
        end
      end
      ST_PUSH_END: begin
        code_req.valid = 1'b1;
        code           = END_CODE;
        if (code_ready) begin
          state_d = ST_PUSH_FLUSH;
        end
      end
      ST_PUSH_FLUSH: begin
        code_req.valid = 1'b1;
        code_req.flush = 1'b1;
        code           = '0;
        if (code_ready) begin
          first_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      epoch_q  <= '0;
      first_q  <= 1'b1;
      last_q   <= 1'b0;
      cur_q    <= '0;
      free_q   <= CODE_BITS'(FIRST_FREE);
      step_q   <= '0;
      probes_q <= '0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      epoch_q  <= epoch_d;
      first_q  <= first_d;
      last_q   <= last_d;
      cur_q    <= cur_d;
      free_q   <= free_d;
      step_q   <= step_d;
      probes_q <= probes_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    rem_q   <= rem_d;
    slot_q  <= slot_d;
    dstep_q <= dstep_d;
  end

  lzwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HASH_TABLE_SIZE)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lzwc_packer #(
    .CODE_BITS (CODE_BITS)
  ) u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_req_i   (code_req),
    .code_i       (code),
    .code_ready_o (code_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_req_o    (out_req_o)
  );

  `LZWC_ASSERT_IMP(a_no_rw_overlap, ram_we, !ram_re, "dictionary read and write together")
  `LZWC_ASSERT_IMP(a_probe_bound, state_q == ST_CHECK,
                   (probes_q != '0) && (probes_q <= PROBE_W'(HASH_TABLE_SIZE)),
                   "probe count out of range")
  `LZWC_ASSERT_NEXT(a_hit_code, (state_q == ST_CHECK) && hit,
                    cur_q >= CODE_BITS'(FIRST_FREE), "dictionary hit gave a literal code")

endmodule

### test/tb_top.sv
module tb_top;
  import lzwc_pkg::*;

  localparam int unsigned CODE_W        = 12;
  localparam int unsigned HASH_SIZE     = 5021;
  localparam int unsigned LAST_NEW_CODE = (1 << CODE_W) - 2;
  localparam int unsigned END_MARK      = (1 << CODE_W) - 1;
  localparam int unsigned WATCHDOG      = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 30;

  class lzw_stream_checker;
    bit          slot_used[HASH_SIZE];
    logic [11:0] slot_code[HASH_SIZE];
    logic [11:0] slot_prefix[HASH_SIZE];
    logic [7:0]  slot_char[HASH_SIZE];
    int unsigned avail_code;
    logic [11:0] cur_str;
    bit          msg_start;
    logic [31:0] acc;
    int unsigned acc_bits;
    bit          saw_full;
    out_req_t    expected_bytes[$];
    int          errors;
    int          n_requests;
    int          n_messages;
    int          n_checked;
    int          full_msgs;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      avail_code = FIRST_FREE;
      cur_str    = '0;
      msg_start  = 1'b1;
      acc        = '0;
      acc_bits   = 0;
      saw_full   = 1'b0;
      errors     = 0;
      n_requests = 0;
      n_messages = 0;
      n_checked  = 0;
      full_msgs  = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int find_slot(logic [11:0] prefix, logic [7:0] ch, output bit hit);
      int unsigned slot;
      int unsigned step;
      slot = (({24'd0, ch} << (CODE_W - 8)) ^ {20'd0, prefix}) % HASH_SIZE;
      step = (slot == 0) ? 1 : HASH_SIZE - slot;
      hit = 1'b0;
      for (int n = 0; n < HASH_SIZE; n++) begin
        if (!slot_used[slot]) return slot;
        if (slot_prefix[slot] == prefix && slot_char[slot] == ch) begin
          hit = 1'b1;
          return slot;
        end
        slot = (slot >= step) ? slot - step : slot + HASH_SIZE - step;
      end
      return -1;
    endfunction

    function void pack_code(logic [11:0] code);
      out_req_t b;
      acc = acc | ({20'd0, code} << (32 - CODE_W - acc_bits));
      acc_bits += CODE_W;
      while (acc_bits >= 8) begin
        b.out_byte = acc[31:24];
        b.out_last = 1'b0;
        expected_bytes.push_back(b);
        acc = acc << 8;
        acc_bits -= 8;
      end
    endfunction

    function void note_request(in_req_t req);
      bit       hit;
      int       slot;
      out_req_t tail;
      n_requests++;
      if (msg_start) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        avail_code = FIRST_FREE;
        cur_str    = {4'd0, req.data_byte};
        msg_start  = 1'b0;
      end else begin
        slot = find_slot(cur_str, req.data_byte, hit);
        if (hit) begin
          cur_str = slot_code[slot];
        end else begin
          if (slot >= 0 && avail_code <= LAST_NEW_CODE) begin
            slot_used[slot]   = 1'b1;
            slot_code[slot]   = avail_code[11:0];
            slot_prefix[slot] = cur_str;
            slot_char[slot]   = req.data_byte;
            avail_code++;
          end else if (!saw_full) begin
            saw_full = 1'b1;
            full_msgs++;
          end
          pack_code(cur_str);
          cur_str = {4'd0, req.data_byte};
        end
      end
      if (req.last_byte) begin
        pack_code(cur_str);
        pack_code(END_MARK[11:0]);
        pack_code(12'd0);
        tail = expected_bytes[expected_bytes.size() - 1];
        expected_bytes.pop_back();
        tail.out_last = 1'b1;
        expected_bytes.push_back(tail);
        msg_start = 1'b1;
        saw_full  = 1'b0;
        n_messages++;
      end
    endfunction

    task check_byte(out_req_t got);
      out_req_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.out_last));
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (got.out_byte !== want.out_byte)
          report($sformatf("byte %0d: out_byte %02h, want %02h",
                           n_checked, got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
          report($sformatf("byte %0d: out_last %0b, want %0b",
                           n_checked, got.out_last, want.out_last));
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  out_req_t out_req_o;

  int tx_idle;
  int rx_idle;
  bit hold_req;
  bit hold_done;

  lzw_stream_checker sb;

  lzw_compressor_12bit_unit #(
    .CODE_BITS      (CODE_W),
    .HASH_TABLE_SIZE(HASH_SIZE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_byte(out_req_o);
    end
  end

  // receiver side, with a one-off long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk_i);
      if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    in_req_t req;
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req.data_byte = b;
    req.last_byte = l;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int len, input bit narrow);
    logic [7:0] base;
    logic [7:0] b;
    base = $urandom_range(255);
    for (int i = 0; i < len; i++) begin
      b = narrow ? base + 8'($urandom_range(3)) : 8'($urandom_range(255));
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic run_random(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      send_message(len, $urandom_range(1));
      sent += len;
    end
  endtask

  initial begin
    sb         = new();
    tx_idle    = 29;
    rx_idle    = 63;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one-byte messages at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // repeats that extend strings through dictionary hits
    for (int i = 0; i < 7; i++) send_byte((i % 2) ? 8'h42 : 8'h41, i == 6);
    for (int i = 0; i < 6; i++) send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 5; i++) send_byte(8'hff, i == 4);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);

    // long receiver stall while requests keep coming
    hold_req = 1'b1;
    send_message(24, 1'b1);
    run_random(16);

    tx_idle = 63;
    rx_idle = 29;
    run_random(16);

    tx_idle = 0;
    rx_idle = 0;
    run_random(16);

    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_bytes.size() != 0)
      sb.report($sformatf("%0d expected bytes never arrived", sb.expected_bytes.size()));

    $display("ran %0d requests in %0d messages, %0d output bytes compared",
             sb.n_requests, sb.n_messages, sb.n_checked);
    $display("code space ran out in %0d message(s); long output stall exercised",
             sb.full_msgs);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
